// ----- rtl/jsl_pkg.sv -----
package jsl_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned KindWidth  = 4;
   localparam int unsigned ValueWidth = 64;

   // Token kinds reported on the result channel.
   localparam logic [KindWidth-1:0] KIND_INT        = 4'd0;
   localparam logic [KindWidth-1:0] KIND_NATURAL    = 4'd1;
   localparam logic [KindWidth-1:0] KIND_REAL       = 4'd2;
   localparam logic [KindWidth-1:0] KIND_TRUE       = 4'd3;
   localparam logic [KindWidth-1:0] KIND_FALSE      = 4'd4;
   localparam logic [KindWidth-1:0] KIND_NULL       = 4'd5;
   localparam logic [KindWidth-1:0] KIND_NUM_ERR    = 4'd6;
   localparam logic [KindWidth-1:0] KIND_REAL_ERR   = 4'd7;
   localparam logic [KindWidth-1:0] KIND_TRUE_ERR   = 4'd8;
   localparam logic [KindWidth-1:0] KIND_FALSE_ERR  = 4'd9;
   localparam logic [KindWidth-1:0] KIND_NULL_ERR   = 4'd10;

   // Literal kinds.
   localparam logic [1:0] LIT_TRUE  = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;
   localparam logic [1:0] LIT_NULL  = 2'd2;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_E  = 8'h45;
   localparam logic [7:0] CHAR_LC_E  = 8'h65;
   localparam logic [7:0] CHAR_LC_T  = 8'h74;
   localparam logic [7:0] CHAR_LC_F  = 8'h66;
   localparam logic [7:0] CHAR_LC_N  = 8'h6E;

   // Expected character at a position after the first letter of a literal.
   function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [1:0] pos);
      logic [7:0] c;
      c = 8'h00;
      unique case (kind)
         LIT_TRUE: begin
            unique case (pos)
               2'd0: c = 8'h72;
               2'd1: c = 8'h75;
               2'd2: c = 8'h65;
               default: c = 8'h00;
            endcase
         end
         LIT_FALSE: begin
            unique case (pos)
               2'd0: c = 8'h61;
               2'd1: c = 8'h6C;
               2'd2: c = 8'h73;
               default: c = 8'h65;
            endcase
         end
         default: begin
            unique case (pos)
               2'd0: c = 8'h75;
               2'd1: c = 8'h6C;
               2'd2: c = 8'h6C;
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   // Index of the last expected character of a literal.
   function automatic logic [1:0] lit_last(input logic [1:0] kind);
      return (kind == LIT_FALSE) ? 2'd3 : 2'd2;
   endfunction

endpackage

// ----- rtl/json_scalar_token_lexer.sv -----
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_text_byte, req_end_of_text
// rsp       out        rsp_valid, rsp_ready, rsp_token_kind, rsp_value_bits,
//                      rsp_terminator_byte, rsp_terminator_valid
//
// One byte per cycle while the result register can take a result. A transfer lands
// in the input register; the lexer state and the 64-bit digit accumulate are then
// updated from it once the result register can take a result, and a result, if any,
// is loaded into the result register in that same update. Reset returns the lexer to
// idle, where bytes that start no token are skipped. When the result register is full
// and not taken, the input register holds and req_ready drops once it is occupied.
module json_scalar_token_lexer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [jsl_pkg::ByteWidth-1:0]      req_text_byte,
   input  logic                               req_end_of_text,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [jsl_pkg::KindWidth-1:0]      rsp_token_kind,
   output logic [jsl_pkg::ValueWidth-1:0]     rsp_value_bits,
   output logic [jsl_pkg::ByteWidth-1:0]      rsp_terminator_byte,
   output logic                               rsp_terminator_valid
);

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_LITERAL  = 3'd1;
   localparam logic [2:0] PH_INT      = 3'd2;
   localparam logic [2:0] PH_FRAC     = 3'd3;
   localparam logic [2:0] PH_EXP_SIGN = 3'd4;
   localparam logic [2:0] PH_EXP_DIG  = 3'd5;

   localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eot_ff;

   // Lexer state.
   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  lit_kind_ff, lit_kind_in;
   logic [1:0]  lit_pos_ff, lit_pos_in;
   logic        neg_ff, neg_in;
   logic        digits_ff, digits_in;
   logic [63:0] mag_ff, mag_in;
   logic        sat_ff, sat_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  out_kind_ff, out_kind_in;
   logic [63:0] out_value_ff, out_value_in;
   logic [7:0]  out_term_ff, out_term_in;
   logic        out_term_valid_ff, out_term_valid_in;

   logic        advance;
   logic        emit;
   logic        emit_int;
   logic        has_term;
   logic [3:0]  kind;
   logic [7:0]  b;
   logic        eot;
   logic        is_digit;
   logic        exp_mark;
   logic [3:0]  d;
   logic [67:0] acc_sum;
   logic        acc_sat;
   logic [63:0] acc_mag;
   logic [63:0] int_value;
   logic [3:0]  int_kind;

   // The stored byte is worked on once the result register can take a result.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign b        = in_byte_ff;
   assign eot      = in_eot_ff;
   assign is_digit = (b >= jsl_pkg::CHAR_ZERO) && (b <= jsl_pkg::CHAR_NINE);
   assign exp_mark = (b == jsl_pkg::CHAR_LC_E) || (b == jsl_pkg::CHAR_UC_E);
   assign d        = b[3:0];

   // Magnitude times ten plus the digit, with saturation on any carry out.
   assign acc_sum = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} + {64'd0, d};
   assign acc_sat = sat_ff || (acc_sum[67:64] != 4'd0);
   assign acc_mag = acc_sat ? {64{1'b1}} : acc_sum[63:0];

   always_comb begin
      if (neg_ff) begin
         int_kind  = jsl_pkg::KIND_INT;
         int_value = (mag_ff > SMAX) ? {1'b1, 63'd0} : (64'd0 - mag_ff);
      end else begin
         int_kind  = mag_ff[63] ? jsl_pkg::KIND_NATURAL : jsl_pkg::KIND_INT;
         int_value = mag_ff;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      lit_kind_in = lit_kind_ff;
      lit_pos_in  = lit_pos_ff;
      neg_in      = neg_ff;
      digits_in   = digits_ff;
      mag_in      = mag_ff;
      sat_in      = sat_ff;
      emit        = 1'b0;
      emit_int    = 1'b0;
      has_term    = !eot;
      kind        = jsl_pkg::KIND_NUM_ERR;

      unique case (phase_ff)
         PH_IDLE: begin
            if (!eot) begin
               if (b == jsl_pkg::CHAR_LC_T || b == jsl_pkg::CHAR_LC_F ||
                   b == jsl_pkg::CHAR_LC_N) begin
                  lit_kind_in = (b == jsl_pkg::CHAR_LC_T) ? jsl_pkg::LIT_TRUE :
                                (b == jsl_pkg::CHAR_LC_F) ? jsl_pkg::LIT_FALSE :
                                                            jsl_pkg::LIT_NULL;
                  lit_pos_in  = 2'd0;
                  phase_in    = PH_LITERAL;
               end else if (b == jsl_pkg::CHAR_MINUS || is_digit) begin
                  neg_in    = (b == jsl_pkg::CHAR_MINUS);
                  digits_in = is_digit;
                  mag_in    = is_digit ? {60'd0, d} : 64'd0;
                  sat_in    = 1'b0;
                  phase_in  = PH_INT;
               end
            end
         end
         PH_LITERAL: begin
            if (eot || b != jsl_pkg::lit_char(lit_kind_ff, lit_pos_ff)) begin
               emit = 1'b1;
               kind = (lit_kind_ff == jsl_pkg::LIT_TRUE)  ? jsl_pkg::KIND_TRUE_ERR  :
                      (lit_kind_ff == jsl_pkg::LIT_FALSE) ? jsl_pkg::KIND_FALSE_ERR :
                                                            jsl_pkg::KIND_NULL_ERR;
            end else if (lit_pos_ff == jsl_pkg::lit_last(lit_kind_ff)) begin
               emit     = 1'b1;
               has_term = 1'b0;
               kind = (lit_kind_ff == jsl_pkg::LIT_TRUE)  ? jsl_pkg::KIND_TRUE  :
                      (lit_kind_ff == jsl_pkg::LIT_FALSE) ? jsl_pkg::KIND_FALSE :
                                                            jsl_pkg::KIND_NULL;
            end else begin
               lit_pos_in = lit_pos_ff + 2'd1;
            end
         end
         PH_INT: begin
            if (!eot && (b == jsl_pkg::CHAR_DOT || exp_mark)) begin
               if (!digits_ff) begin
                  emit = 1'b1;
                  kind = jsl_pkg::KIND_NUM_ERR;
               end else begin
                  digits_in = 1'b0;
                  phase_in  = (b == jsl_pkg::CHAR_DOT) ? PH_FRAC : PH_EXP_SIGN;
               end
            end else if (!eot && is_digit) begin
               digits_in = 1'b1;
               mag_in    = acc_mag;
               sat_in    = acc_sat;
            end else begin
               emit     = 1'b1;
               emit_int = digits_ff;
               kind     = digits_ff ? int_kind : jsl_pkg::KIND_NUM_ERR;
            end
         end
         PH_FRAC: begin
            if (!eot && exp_mark) begin
               if (!digits_ff) begin
                  emit = 1'b1;
                  kind = jsl_pkg::KIND_REAL_ERR;
               end else begin
                  digits_in = 1'b0;
                  phase_in  = PH_EXP_SIGN;
               end
            end else if (!eot && is_digit) begin
               digits_in = 1'b1;
            end else begin
               emit = 1'b1;
               kind = digits_ff ? jsl_pkg::KIND_REAL : jsl_pkg::KIND_REAL_ERR;
            end
         end
         PH_EXP_SIGN: begin
            if (!eot && (is_digit || b == jsl_pkg::CHAR_MINUS || b == jsl_pkg::CHAR_PLUS)) begin
               digits_in = is_digit;
               phase_in  = PH_EXP_DIG;
            end else begin
               emit = 1'b1;
               kind = jsl_pkg::KIND_REAL_ERR;
            end
         end
         PH_EXP_DIG: begin
            if (!eot && is_digit) begin
               digits_in = 1'b1;
            end else begin
               emit = 1'b1;
               kind = digits_ff ? jsl_pkg::KIND_REAL : jsl_pkg::KIND_REAL_ERR;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // Every result sends the lexer back to idle.
      if (emit) begin
         phase_in    = PH_IDLE;
         lit_kind_in = 2'd0;
         lit_pos_in  = 2'd0;
         neg_in      = 1'b0;
         digits_in   = 1'b0;
         mag_in      = 64'd0;
         sat_in      = 1'b0;
      end
   end

   always_comb begin
      in_valid_in       = in_valid_ff;
      out_valid_in      = out_valid_ff;
      out_kind_in       = out_kind_ff;
      out_value_in      = out_value_ff;
      out_term_in       = out_term_ff;
      out_term_valid_in = out_term_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         if (emit) begin
            out_valid_in      = 1'b1;
            out_kind_in       = kind;
            out_value_in      = emit_int ? int_value : 64'd0;
            out_term_in       = has_term ? b : 8'd0;
            out_term_valid_in = has_term;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         lit_kind_ff  <= 2'd0;
         lit_pos_ff   <= 2'd0;
         neg_ff       <= 1'b0;
         digits_ff    <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff    <= phase_in;
            lit_kind_ff <= lit_kind_in;
            lit_pos_ff  <= lit_pos_in;
            neg_ff      <= neg_in;
            digits_ff   <= digits_in;
            sat_ff      <= sat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff <= 64'd0;
      end else if (advance) begin
         mag_ff <= mag_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
      out_kind_ff       <= out_kind_in;
      out_value_ff      <= out_value_in;
      out_term_ff       <= out_term_in;
      out_term_valid_ff <= out_term_valid_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_token_kind       = out_kind_ff;
   assign rsp_value_bits       = out_value_ff;
   assign rsp_terminator_byte  = out_term_ff;
   assign rsp_terminator_valid = out_term_valid_ff;

endmodule

// ----- bench/json_scalar_token_lexer_tb.sv -----
`timescale 1ns / 1ps

module json_scalar_token_lexer_tb;

   typedef logic [jsl_pkg::ByteWidth-1:0]  char_type;
   typedef logic [jsl_pkg::KindWidth-1:0]  kind_type;
   typedef logic [jsl_pkg::ValueWidth-1:0] value_type;

   typedef struct packed {
      kind_type  kind;
      value_type value;
      char_type  term_byte;
      logic      term_valid;
   } token_type;

   typedef struct {
      char_type  text;
      bit        eot;
      bit        given;
      token_type result;
   } script_row_type;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_LITERAL,
      SCAN_INT,
      SCAN_FRAC,
      SCAN_EXP_SIGN,
      SCAN_EXP_DIGITS
   } scan_phase_type;

   localparam value_type ALL_ONES = '1;
   localparam value_type INT_MAX  = {1'b0, {(jsl_pkg::ValueWidth-1){1'b1}}};
   localparam value_type INT_MIN  = {1'b1, {(jsl_pkg::ValueWidth-1){1'b0}}};
   localparam int TOKENS_WANTED   = 1600;
   localparam int PRESSURE_AT     = 600;
   localparam int PRESSURE_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PRINT_LIMIT     = 50;

   logic      clock;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   char_type  req_text_byte = '0;
   logic      req_end_of_text = 1'b0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   kind_type  rsp_token_kind;
   value_type rsp_value_bits;
   char_type  rsp_terminator_byte;
   logic      rsp_terminator_valid;

   // Predictor state.
   scan_phase_type scan_phase;
   string          lit_word;
   logic [1:0]     lit_index;
   int             lit_pos;
   bit             negative;
   bit             have_digits;
   bit             saturated;
   value_type      magnitude;

   token_type      expected_tokens[$];
   script_row_type script_q[$];
   int             sent_count;
   int             ignored_count;
   int             error_count;
   bit             steady;
   bit             hold_request;

   string boundary_digits[$] = '{
      "9223372036854775807", "9223372036854775808", "9223372036854775809",
      "18446744073709551615", "18446744073709551616", "99999999999999999999",
      "0", "00"
   };

   json_scalar_token_lexer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_text_byte        (req_text_byte),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_token_kind       (rsp_token_kind),
      .rsp_value_bits       (rsp_value_bits),
      .rsp_terminator_byte  (rsp_terminator_byte),
      .rsp_terminator_valid (rsp_terminator_valid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(4_000_000);
      $display("json_scalar_token_lexer_tb failed");
      $finish;
   end

   function automatic void clear_scan();
      scan_phase  = SCAN_IDLE;
      lit_word    = "";
      lit_index   = jsl_pkg::LIT_TRUE;
      lit_pos     = 0;
      negative    = 1'b0;
      have_digits = 1'b0;
      saturated   = 1'b0;
      magnitude   = '0;
   endfunction

   function automatic token_type close_token(input kind_type kind,
                                             input value_type value,
                                             input bit has_term, input char_type c);
      token_type tok;
      tok.kind       = kind;
      tok.value      = value;
      tok.term_byte  = has_term ? c : '0;
      tok.term_valid = has_term;
      clear_scan();
      return tok;
   endfunction

   function automatic token_type close_integer(input bit has_term, input char_type c);
      if (negative) begin
         // Anything beyond 2^63 clamps to the most negative value.
         return close_token(jsl_pkg::KIND_INT,
                            (magnitude > INT_MAX) ? INT_MIN : '0 - magnitude,
                            has_term, c);
      end
      if (magnitude <= INT_MAX)
         return close_token(jsl_pkg::KIND_INT, magnitude, has_term, c);
      return close_token(jsl_pkg::KIND_NATURAL, magnitude, has_term, c);
   endfunction

   function automatic void add_digit(input char_type c);
      value_type d;
      d = value_type'(c - jsl_pkg::CHAR_ZERO);
      if (saturated || magnitude > (ALL_ONES - d) / 10) begin
         magnitude = ALL_ONES;
         saturated = 1'b1;
      end else begin
         magnitude = magnitude * 10 + d;
      end
   endfunction

   // Advances the predictor by one transfer; returns 1 when a token is complete.
   function automatic bit lex_predict(input char_type c, input bit eot,
                                      output token_type tok);
      bit digit;
      bit exp_mark;
      bit got;
      digit    = (c >= jsl_pkg::CHAR_ZERO && c <= jsl_pkg::CHAR_NINE);
      exp_mark = (c == jsl_pkg::CHAR_LC_E || c == jsl_pkg::CHAR_UC_E);
      got      = 1'b0;
      tok      = '0;
      case (scan_phase)
         SCAN_IDLE: begin
            if (eot) begin
               ignored_count++;
            end else if (c == jsl_pkg::CHAR_LC_T || c == jsl_pkg::CHAR_LC_F ||
                         c == jsl_pkg::CHAR_LC_N) begin
               if (c == jsl_pkg::CHAR_LC_T) begin
                  lit_word  = "true";
                  lit_index = jsl_pkg::LIT_TRUE;
               end else if (c == jsl_pkg::CHAR_LC_F) begin
                  lit_word  = "false";
                  lit_index = jsl_pkg::LIT_FALSE;
               end else begin
                  lit_word  = "null";
                  lit_index = jsl_pkg::LIT_NULL;
               end
               lit_pos    = 1;
               scan_phase = SCAN_LITERAL;
            end else if (c == jsl_pkg::CHAR_MINUS || digit) begin
               negative    = (c == jsl_pkg::CHAR_MINUS);
               have_digits = digit;
               magnitude   = '0;
               saturated   = 1'b0;
               if (digit)
                  add_digit(c);
               scan_phase = SCAN_INT;
            end else begin
               ignored_count++;
            end
         end
         SCAN_LITERAL: begin
            got = 1'b1;
            if (eot)
               tok = close_token(jsl_pkg::KIND_TRUE_ERR + lit_index, '0, 1'b0, c);
            else if (c != char_type'(lit_word[lit_pos]))
               tok = close_token(jsl_pkg::KIND_TRUE_ERR + lit_index, '0, 1'b1, c);
            else if (lit_pos == lit_word.len() - 1)
               tok = close_token(jsl_pkg::KIND_TRUE + lit_index, '0, 1'b0, c);
            else begin
               lit_pos++;
               got = 1'b0;
            end
         end
         SCAN_INT: begin
            if (eot) begin
               got = 1'b1;
               tok = have_digits ? close_integer(1'b0, c)
                                 : close_token(jsl_pkg::KIND_NUM_ERR, '0, 1'b0, c);
            end else if (c == jsl_pkg::CHAR_DOT || exp_mark) begin
               if (!have_digits) begin
                  got = 1'b1;
                  tok = close_token(jsl_pkg::KIND_NUM_ERR, '0, 1'b1, c);
               end else begin
                  have_digits = 1'b0;
                  scan_phase  = (c == jsl_pkg::CHAR_DOT) ? SCAN_FRAC : SCAN_EXP_SIGN;
               end
            end else if (digit) begin
               have_digits = 1'b1;
               add_digit(c);
            end else begin
               got = 1'b1;
               tok = have_digits ? close_integer(1'b1, c)
                                 : close_token(jsl_pkg::KIND_NUM_ERR, '0, 1'b1, c);
            end
         end
         SCAN_FRAC: begin
            if (eot) begin
               got = 1'b1;
               tok = close_token(have_digits ? jsl_pkg::KIND_REAL : jsl_pkg::KIND_REAL_ERR,
                                 '0, 1'b0, c);
            end else if (exp_mark) begin
               if (!have_digits) begin
                  got = 1'b1;
                  tok = close_token(jsl_pkg::KIND_REAL_ERR, '0, 1'b1, c);
               end else begin
                  have_digits = 1'b0;
                  scan_phase  = SCAN_EXP_SIGN;
               end
            end else if (digit) begin
               have_digits = 1'b1;
            end else begin
               got = 1'b1;
               tok = close_token(have_digits ? jsl_pkg::KIND_REAL : jsl_pkg::KIND_REAL_ERR,
                                 '0, 1'b1, c);
            end
         end
         SCAN_EXP_SIGN: begin
            if (eot) begin
               got = 1'b1;
               tok = close_token(jsl_pkg::KIND_REAL_ERR, '0, 1'b0, c);
            end else if (digit || c == jsl_pkg::CHAR_MINUS || c == jsl_pkg::CHAR_PLUS) begin
               have_digits = digit;
               scan_phase  = SCAN_EXP_DIGITS;
            end else begin
               got = 1'b1;
               tok = close_token(jsl_pkg::KIND_REAL_ERR, '0, 1'b1, c);
            end
         end
         SCAN_EXP_DIGITS: begin
            if (eot) begin
               got = 1'b1;
               tok = close_token(have_digits ? jsl_pkg::KIND_REAL : jsl_pkg::KIND_REAL_ERR,
                                 '0, 1'b0, c);
            end else if (digit) begin
               have_digits = 1'b1;
            end else begin
               got = 1'b1;
               tok = close_token(have_digits ? jsl_pkg::KIND_REAL : jsl_pkg::KIND_REAL_ERR,
                                 '0, 1'b1, c);
            end
         end
         default: clear_scan();
      endcase
      return got;
   endfunction

   task automatic report_mismatch(input string what, input value_type got,
                                  input value_type want);
      if (error_count < PRINT_LIMIT)
         $display("%0t: %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(15, 30);
   endfunction

   task automatic send_text(input char_type c, input bit eot, input bit given,
                            input token_type fixed);
      token_type tok;
      bit        got;
      int        gap;
      req_valid       <= 1'b1;
      req_text_byte   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      got = lex_predict(c, eot, tok);
      if (given)
         expected_tokens.push_back(fixed);
      else if (got)
         expected_tokens.push_back(tok);
      gap = steady ? 0 : idle_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_byte(input char_type c);
      send_text(c, 1'b0, 1'b0, '0);
   endtask

   task automatic send_end();
      send_text(char_type'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
   endtask

   task automatic send_digits();
      int    pick;
      int    n;
      string s;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         s = boundary_digits[$urandom_range(0, boundary_digits.size() - 1)];
         for (int i = 0; i < s.len(); i++)
            send_byte(char_type'(s[i]));
      end else begin
         if (pick < 6)
            n = $urandom_range(1, 4);
         else if (pick < 9)
            n = $urandom_range(5, 19);
         else
            n = $urandom_range(20, 24);
         repeat (n) send_byte(char_type'(jsl_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end
   endtask

   task automatic send_terminator();
      case ($urandom_range(0, 7))
         0: send_byte(",");
         1: send_byte(jsl_pkg::CHAR_SPACE);
         2: send_byte("]");
         3: send_byte("}");
         4: send_byte(jsl_pkg::CHAR_LF);
         5: send_end();
         default: send_byte(char_type'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic send_number();
      if ($urandom_range(0, 2) == 0)
         send_byte(jsl_pkg::CHAR_MINUS);
      if ($urandom_range(0, 9) != 0)
         send_digits();
      if ($urandom_range(0, 3) == 0) begin
         send_byte(jsl_pkg::CHAR_DOT);
         if ($urandom_range(0, 7) != 0)
            send_digits();
      end
      if ($urandom_range(0, 4) == 0) begin
         send_byte($urandom_range(0, 1) ? jsl_pkg::CHAR_LC_E : jsl_pkg::CHAR_UC_E);
         case ($urandom_range(0, 3))
            0: send_byte(jsl_pkg::CHAR_PLUS);
            1: send_byte(jsl_pkg::CHAR_MINUS);
            default: ;
         endcase
         if ($urandom_range(0, 7) != 0)
            send_digits();
      end
      send_terminator();
   endtask

   task automatic send_literal();
      string word;
      int    mode;
      int    cut;
      case ($urandom_range(0, 2))
         0: word = "true";
         1: word = "false";
         default: word = "null";
      endcase
      mode = $urandom_range(0, 9);
      cut  = (mode < 7) ? word.len() : $urandom_range(1, word.len() - 1);
      for (int i = 0; i < cut; i++)
         send_byte(char_type'(word[i]));
      // A stray byte usually breaks the literal; end of text always does.
      if (mode == 7 || mode == 8)
         send_byte(char_type'($urandom_range(0, 255)));
      else if (mode == 9)
         send_end();
   endtask

   task automatic add_step(input char_type text, input bit eot);
      script_row_type row;
      row.text   = text;
      row.eot    = eot;
      row.given  = 1'b0;
      row.result = '0;
      script_q.push_back(row);
   endtask

   task automatic add_check(input char_type text, input bit eot,
                            input kind_type kind,
                            input value_type value,
                            input char_type term, input bit term_valid);
      script_row_type row;
      row.text              = text;
      row.eot               = eot;
      row.given             = 1'b1;
      row.result.kind       = kind;
      row.result.value      = value;
      row.result.term_byte  = term;
      row.result.term_valid = term_valid;
      script_q.push_back(row);
   endtask

   // Result side: checks every transfer and stalls at random.
   initial begin : result_side
      int        stall_left;
      int        hold_left;
      token_type want;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected result, kind", value_type'(rsp_token_kind), '0);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_token_kind !== want.kind)
                  report_mismatch("token kind", value_type'(rsp_token_kind),
                                  value_type'(want.kind));
               if (rsp_value_bits !== want.value)
                  report_mismatch("value", rsp_value_bits, want.value);
               if (rsp_terminator_byte !== want.term_byte)
                  report_mismatch("terminator byte", value_type'(rsp_terminator_byte),
                                  value_type'(want.term_byte));
               if (rsp_terminator_valid !== want.term_valid)
                  report_mismatch("terminator valid", value_type'(rsp_terminator_valid),
                                  value_type'(want.term_valid));
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = PRESSURE_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
               stall_left = idle_cycles();
            if (stall_left != 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin : text_side
      bit pressure_done;
      pressure_done = 1'b0;
      sent_count    = 0;
      ignored_count = 0;
      error_count   = 0;
      steady        = 1'b0;
      hold_request  = 1'b0;
      clear_scan();

      add_step("t", 1'b0);
      add_step("r", 1'b0);
      add_step("u", 1'b0);
      add_check("e", 1'b0, jsl_pkg::KIND_TRUE, '0, '0, 1'b0);
      add_step("f", 1'b0);
      add_step("a", 1'b0);
      add_step("l", 1'b0);
      add_step("s", 1'b0);
      add_check("e", 1'b0, jsl_pkg::KIND_FALSE, '0, '0, 1'b0);
      add_step("n", 1'b0);
      add_step("u", 1'b0);
      add_check("x", 1'b0, jsl_pkg::KIND_NULL_ERR, '0, "x", 1'b1);
      add_step(jsl_pkg::CHAR_NUL, 1'b0);
      add_step(8'hFF, 1'b0);
      add_step(8'hA5, 1'b1);
      add_step(jsl_pkg::CHAR_MINUS, 1'b0);
      add_check(jsl_pkg::CHAR_DOT, 1'b0, jsl_pkg::KIND_NUM_ERR, '0, jsl_pkg::CHAR_DOT, 1'b1);
      add_step("0", 1'b0);
      add_step(jsl_pkg::CHAR_LC_E, 1'b0);
      add_check(8'h00, 1'b1, jsl_pkg::KIND_REAL_ERR, '0, '0, 1'b0);
      add_step("9", 1'b0);
      add_check(",", 1'b0, jsl_pkg::KIND_INT, 64'd9, ",", 1'b1);
      add_step("1", 1'b0);
      add_step(jsl_pkg::CHAR_DOT, 1'b0);
      add_step("5", 1'b0);
      add_check(8'hFF, 1'b1, jsl_pkg::KIND_REAL, '0, '0, 1'b0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script_q[i])
         send_text(script_q[i].text, script_q[i].eot, script_q[i].given,
                   script_q[i].result);

      while (sent_count - ignored_count < TOKENS_WANTED) begin
         if ($urandom_range(0, 59) == 0)
            steady = !steady;
         // One long receiver hold-off so the block backs up into its input.
         if (!pressure_done && sent_count >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            steady        = 1'b0;
            hold_request  = 1'b1;
         end
         case ($urandom_range(0, 19))
            0, 1: send_byte(char_type'($urandom_range(0, 255)));
            2, 3: begin
               case ($urandom_range(0, 4))
                  0: send_byte(jsl_pkg::CHAR_NUL);
                  1: send_byte(jsl_pkg::CHAR_TAB);
                  2: send_byte(jsl_pkg::CHAR_LF);
                  3: send_byte(jsl_pkg::CHAR_CR);
                  default: send_byte(jsl_pkg::CHAR_SPACE);
               endcase
            end
            4: send_end();
            5, 6, 7, 8, 9, 10: send_literal();
            default: send_number();
         endcase
      end
      req_valid <= 1'b0;
      steady    = 1'b0;

      while (expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("json_scalar_token_lexer_tb passed");
      else
         $display("json_scalar_token_lexer_tb failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/jsl_pkg.sv
rtl/json_scalar_token_lexer.sv
bench/json_scalar_token_lexer_tb.sv
